// ===== rtl/sba_pkg.sv =====
// sba_pkg: shared types and constants for the sector bitmap allocator
`timescale 1ns / 1ps
`default_nettype none
package sba_pkg;

  localparam int MAX_HEADS   = 8;
  localparam int MAX_TRACKS  = 64;
  localparam int MAX_SECTORS = 64;
  localparam int WORD_BITS   = 64;
  localparam int WORDS       = MAX_HEADS * MAX_TRACKS * MAX_SECTORS / WORD_BITS;
  localparam int ADDR_W      = $clog2(WORDS);
  localparam int BIT_W       = $clog2(WORD_BITS);

  localparam logic [1:0] CMD_MARK_USED = 2'd0;
  localparam logic [1:0] CMD_MARK_FREE = 2'd1;
  localparam logic [1:0] CMD_SEARCH_SM = 2'd2;
  localparam logic [1:0] CMD_SEARCH_CY = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [1:0] REG_HEADS   = 2'd0;
  localparam logic [1:0] REG_TRACKS  = 2'd1;
  localparam logic [1:0] REG_SECTORS = 2'd2;
  localparam logic [1:0] REG_STRIDE  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [14:0] sector_id;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] found_sector;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_TOTAL,
    OP_DEC_H,
    OP_DEC_T,
    OP_INIT,
    OP_READ,
    OP_WRITE,
    OP_ADVANCE,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] res_status;
    logic       res_found;
  } dp_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       clr_last;
    logic       range_bad;
    logic       dec_h_done;
    logic       dec_t_done;
    logic       bit_used;
    logic       last_cand;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/sba_dp.sv =====
// sba_dp: bitmap memory, geometry, search counters and result registers
`timescale 1ns / 1ps
`default_nettype none
module sba_dp import sba_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  input  request_t      request,
  input  dp_ctl_t       ctl,
  output dp_stat_t      stat,
  output logic          done,
  output result_t       result
);

  logic [3:0]  heads_q;
  logic [6:0]  tracks_q, sectors_q, stride_q;
  logic [3:0]  h_lim;
  logic [6:0]  t_lim, s_lim, step;

  logic [1:0]  cmd_q;
  logic [14:0] id_q;
  logic [12:0] ts;
  logic [15:0] total;
  logic [14:0] rem;
  logic [3:0]  h;
  logic [6:0]  t;
  logic [6:0]  s;
  logic [14:0] hb;
  logic [14:0] tb;
  logic [ADDR_W-1:0] clr_cnt;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rd_data;

  logic [15:0] cand_sum;
  logic [14:0] cand;
  logic [7:0]  s_step;
  logic        s_wrap;
  logic [15:0] tb_next_end;
  logic [ADDR_W-1:0] rd_addr;
  logic [BIT_W-1:0]  bit_sel;
  logic [WORD_BITS-1:0] bit_mask;

  always_comb begin
    h_lim = (heads_q == 4'd0) ? 4'd1 : (heads_q > 4'(MAX_HEADS)) ? 4'(MAX_HEADS) : heads_q;
    t_lim = (tracks_q == 7'd0) ? 7'd1 :
            (tracks_q > 7'(MAX_TRACKS)) ? 7'(MAX_TRACKS) : tracks_q;
    s_lim = (sectors_q == 7'd0) ? 7'd1 :
            (sectors_q > 7'(MAX_SECTORS)) ? 7'(MAX_SECTORS) : sectors_q;
    step  = (stride_q == 7'd0) ? 7'd1 :
            (stride_q > 7'(MAX_SECTORS)) ? 7'(MAX_SECTORS) : stride_q;
  end

  always_comb begin
    cand_sum    = {1'b0, hb} + {1'b0, tb} + {9'd0, s};
    cand        = cand_sum[14:0];
    s_step      = {1'b0, s} + {1'b0, step};
    s_wrap      = (s_step >= {1'b0, s_lim});
    tb_next_end = {1'b0, tb} + {9'd0, s_lim};
    if (ctl.op == OP_READ && (cmd_q == CMD_MARK_USED || cmd_q == CMD_MARK_FREE)) begin
      rd_addr = id_q[14:BIT_W];
    end else begin
      rd_addr = cand[14:BIT_W];
    end
    if (cmd_q == CMD_MARK_USED || cmd_q == CMD_MARK_FREE) begin
      bit_sel = id_q[BIT_W-1:0];
    end else begin
      bit_sel = cand[BIT_W-1:0];
    end
    bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;
  end

  always_comb begin
    stat.cmd        = cmd_q;
    stat.clr_last   = (clr_cnt == ADDR_W'(WORDS - 1));
    stat.range_bad  = ({1'b0, id_q} >= total);
    stat.dec_h_done = (rem < {2'b0, ts});
    stat.dec_t_done = (rem < {8'd0, s_lim});
    stat.bit_used   = |(rd_data & bit_mask);
    if (cmd_q == CMD_SEARCH_SM) begin
      stat.last_cand = s_wrap && (tb_next_end >= total);
    end else begin
      stat.last_cand = ((h + 4'd1) >= h_lim) && s_wrap && ({1'b0, t} + 8'd1 >= {1'b0, t_lim});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heads_q   <= 4'd8;
      tracks_q  <= 7'd64;
      sectors_q <= 7'd64;
      stride_q  <= 7'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADS:   heads_q   <= cfg_data[3:0];
        REG_TRACKS:  tracks_q  <= cfg_data;
        REG_SECTORS: sectors_q <= cfg_data;
        REG_STRIDE:  stride_q  <= cfg_data;
        default:     heads_q   <= heads_q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= (ctl.op == OP_RESULT);
      if (ctl.op == OP_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd_q <= request.command;
        id_q  <= request.sector_id;
        rem   <= request.sector_id;
        ts    <= {6'd0, t_lim} * {6'd0, s_lim};
        h     <= '0;
        t     <= '0;
        s     <= '0;
        hb    <= '0;
        tb    <= '0;
      end
      OP_TOTAL: total <= {12'd0, h_lim} * {3'd0, ts};
      OP_DEC_H: begin
        rem <= rem - {2'b0, ts};
        h   <= h + 4'd1;
        hb  <= hb + {2'b0, ts};
      end
      OP_DEC_T: begin
        rem <= rem - {8'd0, s_lim};
        t   <= t + 7'd1;
        tb  <= tb + {8'd0, s_lim};
      end
      OP_INIT: s <= rem[6:0];
      OP_ADVANCE: begin
        if (cmd_q == CMD_SEARCH_SM) begin
          if (s_wrap) begin
            s  <= '0;
            tb <= tb + {8'd0, s_lim};
          end else begin
            s <= s_step[6:0];
          end
        end else if ((h + 4'd1) < h_lim) begin
          h  <= h + 4'd1;
          hb <= hb + {2'b0, ts};
        end else begin
          h  <= '0;
          hb <= '0;
          if (s_wrap) begin
            s  <= '0;
            t  <= t + 7'd1;
            tb <= tb + {8'd0, s_lim};
          end else begin
            s <= s_step[6:0];
          end
        end
      end
      OP_RESULT: begin
        result.status       <= ctl.res_status;
        result.found_sector <= ctl.res_found ? cand : 15'd0;
      end
      default: rem <= rem;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_CLEAR) begin
      mem[clr_cnt] <= '0;
    end else if (ctl.op == OP_WRITE) begin
      if (cmd_q == CMD_MARK_USED) begin
        mem[id_q[14:BIT_W]] <= rd_data | bit_mask;
      end else begin
        mem[id_q[14:BIT_W]] <= rd_data & ~bit_mask;
      end
    end
    if (ctl.op == OP_READ) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sba_ctrl.sv =====
// sba_ctrl: command sequencer for the sector bitmap allocator
`timescale 1ns / 1ps
`default_nettype none
module sba_ctrl import sba_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  dp_stat_t  stat,
  output dp_ctl_t   ctl,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_TOTAL,
    S_DISPATCH,
    S_MRD,
    S_MWR,
    S_DECH,
    S_DECT,
    S_SRD,
    S_CHK,
    S_RESULT
  } state_t;

  state_t     state, state_next;
  logic [1:0] res_status, res_status_next;
  logic       res_found, res_found_next;
  dp_op_t     op;

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_found_next  = res_found;
    op              = OP_NONE;
    case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op         = OP_LOAD;
          state_next = S_TOTAL;
        end
      end
      S_TOTAL: begin
        op         = OP_TOTAL;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        res_found_next = 1'b0;
        if (stat.cmd == CMD_SEARCH_SM) begin
          state_next = S_SRD;
        end else if (stat.range_bad) begin
          res_status_next = ST_RANGE;
          state_next      = S_RESULT;
        end else if (stat.cmd == CMD_SEARCH_CY) begin
          state_next = S_DECH;
        end else begin
          state_next = S_MRD;
        end
      end
      S_MRD: begin
        op         = OP_READ;
        state_next = S_MWR;
      end
      S_MWR: begin
        op              = OP_WRITE;
        res_status_next = ST_OK;
        state_next      = S_RESULT;
      end
      S_DECH: begin
        if (stat.dec_h_done) begin
          state_next = S_DECT;
        end else begin
          op = OP_DEC_H;
        end
      end
      S_DECT: begin
        if (stat.dec_t_done) begin
          op         = OP_INIT;
          state_next = S_SRD;
        end else begin
          op = OP_DEC_T;
        end
      end
      S_SRD: begin
        op         = OP_READ;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (!stat.bit_used) begin
          res_status_next = ST_OK;
          res_found_next  = 1'b1;
          state_next      = S_RESULT;
        end else if (stat.last_cand) begin
          res_status_next = ST_NO_FREE;
          state_next      = S_RESULT;
        end else begin
          op         = OP_ADVANCE;
          state_next = S_SRD;
        end
      end
      S_RESULT: begin
        op         = OP_RESULT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      res_status <= ST_OK;
      res_found  <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_found  <= res_found_next;
    end
  end

  assign busy           = (state != S_IDLE);
  assign ctl.op         = op;
  assign ctl.res_status = res_status;
  assign ctl.res_found  = res_found;

  a_mwr_after_mrd: assert property (@(posedge clk) disable iff (rst)
    (state == S_MWR) |-> ($past(state) == S_MRD))
    else $error("bitmap write without preceding read");

  a_chk_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> ($past(state) == S_SRD))
    else $error("candidate check without fresh read");

  a_found_is_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && res_found) |-> (res_status == ST_OK && !stat.bit_used))
    else $error("found sector is not free");

endmodule
`default_nettype wire

// ===== rtl/sector_bitmap_allocator.sv =====
// sector_bitmap_allocator: top level, sequencer plus bitmap datapath
`timescale 1ns / 1ps
`default_nettype none
// After reset the block clears its 512-word bitmap, one word per cycle, and holds busy
// high until the clear is done; register writes are taken during that time. A transaction
// starts when start is high and busy is low and ends with done high for exactly one
// cycle, with result valid in that cycle; the receiver cannot stall it. A mark loads the
// request, computes the disk total, reads the bitmap word and writes it back, or skips to
// the result with a range error. A search has the same setup, then a memory read and a
// check per candidate sector; the cylinder-order search first splits the start sector id
// into head and track by repeated subtraction. A search over a full 8 x 64 x 64 disk at
// stride 4 visits up to 8192 candidates.
module sector_bitmap_allocator import sba_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  input  wire logic       start,
  input  request_t        request,
  output logic            busy,
  output logic            done,
  output result_t         result
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  sba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  sba_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .ctl       (ctl),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule
`default_nettype wire
